// File: design/lfu_name_cache_replacement_core_defines.svh
// assertion macros for the lfu name cache replacement core
`ifndef LFU_NAME_CACHE_REPLACEMENT_CORE_DEFINES_SVH
`define LFU_NAME_CACHE_REPLACEMENT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LFU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfu assertion failed");

// next-cycle implication
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfu assertion failed");

`else

`define LFU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/lfu_pkg.sv
// shared types, constants and functions of the lfu name cache core
`timescale 1ns / 1ps
package lfu_pkg;

   localparam int DEF_ENTRIES = 64;
   localparam int TAG_W       = 16;
   localparam int COUNT_W     = 15;
   localparam int SLOT_W      = 6;
   localparam int STATUS_W    = 2;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT    = COUNT_W'(30000);
   localparam logic [COUNT_W-1:0] COUNT_FALLBACK = COUNT_W'(10000);
   localparam logic [COUNT_W-1:0] COUNT_FILL     = COUNT_W'(1);

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_NULL = 2'd0,
      STATUS_HIT  = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic clear;
      logic check;
   } scan_ctrl_type;

   // usage count after a hit, with fall back at the limit
   function automatic logic [COUNT_W-1:0] next_count(input logic [COUNT_W-1:0] cnt);
      logic [COUNT_W:0] sum;
      sum = {1'b0, cnt} + {{COUNT_W{1'b0}}, 1'b1};
      if (sum >= {1'b0, COUNT_LIMIT}) begin
         return COUNT_FALLBACK;
      end
      return sum[COUNT_W-1:0];
   endfunction

endpackage

// File: design/lfu_channels.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface lfu_req_if;
   import lfu_pkg::*;
   logic               valid;
   logic               ready;
   logic               present;
   logic [TAG_W-1:0]   symbol_index;

   modport source (output valid, output present, output symbol_index, input ready);
   modport sink   (input valid, input present, input symbol_index, output ready);
endinterface

interface lfu_rsp_if;
   import lfu_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

// File: design/lfu_entry_store.sv
// tag and count memory with per-entry valid bits
`timescale 1ns / 1ps
module lfu_entry_store #(
   parameter int ENTRIES = lfu_pkg::DEF_ENTRIES,
   parameter int IDX_W   = $clog2(ENTRIES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [lfu_pkg::TAG_W-1:0]   wr_tag,
   input  logic [lfu_pkg::COUNT_W-1:0] wr_count,
   output logic                        q_live,
   output logic [IDX_W-1:0]            q_idx,
   output logic                        q_valid,
   output logic [lfu_pkg::TAG_W-1:0]   q_tag,
   output logic [lfu_pkg::COUNT_W-1:0] q_count
);
   import lfu_pkg::*;

   localparam int WORD_W = TAG_W + COUNT_W;

   logic [WORD_W-1:0]  mem_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic               rd_valid_ff;
   logic               q_live_ff;
   logic [IDX_W-1:0]   q_idx_ff;

   // memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_tag, wr_count};
      end
   end

   // registered memory read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // read side tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         q_live_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
         q_idx_ff    <= '0;
      end else begin
         q_live_ff <= rd_en;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
            q_idx_ff    <= rd_addr;
         end
      end
   end

   // an unfilled entry reads as tag zero, count zero
   assign q_live  = q_live_ff;
   assign q_idx   = q_idx_ff;
   assign q_valid = rd_valid_ff;
   assign q_tag   = rd_valid_ff ? rd_data_ff[WORD_W-1:COUNT_W] : '0;
   assign q_count = rd_valid_ff ? rd_data_ff[COUNT_W-1:0] : '0;

endmodule

// File: design/lfu_match_unit.sv
// shared tag compare and minimum count tracker for the entry scan
`timescale 1ns / 1ps
module lfu_match_unit #(
   parameter int IDX_W = $clog2(lfu_pkg::DEF_ENTRIES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfu_pkg::scan_ctrl_type        ctrl,
   input  logic [lfu_pkg::TAG_W-1:0]     req_tag,
   input  logic                          q_valid,
   input  logic [lfu_pkg::TAG_W-1:0]     q_tag,
   input  logic [lfu_pkg::COUNT_W-1:0]   q_count,
   input  logic [IDX_W-1:0]              q_idx,
   output logic                          match_now,
   output logic                          hit,
   output logic [IDX_W-1:0]              hit_idx,
   output logic [lfu_pkg::COUNT_W-1:0]   hit_count,
   output logic [IDX_W-1:0]              victim_idx
);
   import lfu_pkg::*;

   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [COUNT_W-1:0]  hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]    victim_ff, victim_in;

   assign match_now = ctrl.check && q_valid && (q_tag == req_tag);

   // hit capture and running minimum, first smallest wins
   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_count_in = hit_count_ff;
      best_in      = best_ff;
      victim_in    = victim_ff;
      if (ctrl.clear) begin
         hit_in    = 1'b0;
         best_in   = COUNT_LIMIT;
         victim_in = '0;
      end else if (match_now) begin
         hit_in       = 1'b1;
         hit_idx_in   = q_idx;
         hit_count_in = q_count;
      end else if (ctrl.check && (q_count < best_ff)) begin
         best_in   = q_count;
         victim_in = q_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      best_ff      <= best_in;
      victim_ff    <= victim_in;
   end

   assign hit        = hit_ff;
   assign hit_idx    = hit_idx_ff;
   assign hit_count  = hit_count_ff;
   assign victim_idx = victim_ff;

endmodule

// File: design/lfu_name_cache_replacement_core.sv
// Top level of the lfu name cache replacement core.
//
// req_chan carries one lookup: present and symbol_index. rsp_chan returns
// exactly one result per lookup: status (null, hit or miss) and slot.
// Both channels transfer on a clock edge with valid and ready high.
// A lookup with present low answers null and touches no state.
// A present lookup scans the tag and count memory one entry per cycle
// through its single read port, from slot 0 upward, and stops at the first
// valid tag match or after the last entry. The next lookup is taken once the
// result is in the output register. On a hit the count rises by one (30000
// falls back to 10000); on a miss the first entry with the smallest count
// gets the tag and count 1.
// The result register holds while rsp_chan.ready is low; a new lookup may
// be taken meanwhile, but its result waits until the register is free.
// Reset (synchronous) clears all valid bits, so every entry is empty.
`timescale 1ns / 1ps
`include "lfu_name_cache_replacement_core_defines.svh"
module lfu_name_cache_replacement_core #(
   parameter int ENTRIES = lfu_pkg::DEF_ENTRIES
) (
   input  logic   clock,
   input  logic   reset,
   lfu_req_if.sink   req_chan,
   lfu_rsp_if.source rsp_chan
);
   import lfu_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type           state_ff, state_in;
   logic                present_ff, present_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [IDX_W-1:0]    issue_idx_ff, issue_idx_in;
   logic                issue_done_ff, issue_done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                req_xfer;
   logic                out_free;
   logic                scan_end;
   logic                rsp_load;
   logic                rd_en;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [COUNT_W-1:0]  wr_count;
   scan_ctrl_type       scan_ctrl;

   logic                q_live;
   logic [IDX_W-1:0]    q_idx;
   logic                q_valid;
   logic [TAG_W-1:0]    q_tag;
   logic [COUNT_W-1:0]  q_count;
   logic                match_now;
   logic                hit;
   logic [IDX_W-1:0]    hit_idx;
   logic [COUNT_W-1:0]  hit_count;
   logic [IDX_W-1:0]    victim_idx;

   lfu_entry_store #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (issue_idx_ff),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_tag   (tag_ff),
      .wr_count (wr_count),
      .q_live   (q_live),
      .q_idx    (q_idx),
      .q_valid  (q_valid),
      .q_tag    (q_tag),
      .q_count  (q_count)
   );

   lfu_match_unit #(
      .IDX_W (IDX_W)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .req_tag    (tag_ff),
      .q_valid    (q_valid),
      .q_tag      (q_tag),
      .q_count    (q_count),
      .q_idx      (q_idx),
      .match_now  (match_now),
      .hit        (hit),
      .hit_idx    (hit_idx),
      .hit_count  (hit_count),
      .victim_idx (victim_idx)
   );

   // handshake helpers
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign scan_end = q_live && (match_now || (q_idx == LAST_IDX));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = req_chan.present ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready  = 1'b0;
      rd_en           = 1'b0;
      scan_ctrl.clear = 1'b0;
      scan_ctrl.check = 1'b0;
      rsp_load        = 1'b0;
      wr_en           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready  = 1'b1;
            scan_ctrl.clear = 1'b1;
         end
         ST_SCAN: begin
            rd_en           = !issue_done_ff;
            scan_ctrl.check = q_live;
         end
         ST_DONE: begin
            rsp_load = out_free;
            wr_en    = out_free && present_ff;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // write back: bump the hit count or refill the victim
   assign wr_addr  = hit ? hit_idx : victim_idx;
   assign wr_count = hit ? next_count(hit_count) : COUNT_FILL;

   // datapath next values
   always_comb begin
      present_in    = present_ff;
      tag_in        = tag_ff;
      issue_idx_in  = issue_idx_ff;
      issue_done_in = issue_done_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (req_xfer) begin
         present_in    = req_chan.present;
         tag_in        = req_chan.symbol_index;
         issue_idx_in  = '0;
         issue_done_in = 1'b0;
      end
      if (rd_en) begin
         if (issue_idx_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end else begin
            issue_idx_in = issue_idx_ff + 1'b1;
         end
      end
      // response register
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (!present_ff) begin
            rsp_status_in = STATUS_NULL;
            rsp_slot_in   = '0;
         end else if (hit) begin
            rsp_status_in = STATUS_HIT;
            rsp_slot_in   = SLOT_W'(hit_idx);
         end else begin
            rsp_status_in = STATUS_MISS;
            rsp_slot_in   = SLOT_W'(victim_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      present_ff    <= present_in;
      tag_ff        <= tag_in;
      issue_idx_ff  <= issue_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;

   // checks
   `LFU_ASSERT_NEXT(a_null_skips_scan, clock, reset, req_xfer && !req_chan.present, state_ff == ST_DONE)
   `LFU_ASSERT_IMPL(a_load_returns_idle, clock, reset, $rose(rsp_valid_ff), state_ff == ST_IDLE)
   `LFU_ASSERT_IMPL(a_null_slot_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == STATUS_NULL), rsp_slot_ff == '0)
   `LFU_ASSERT_IMPL(a_no_write_while_scan, clock, reset, wr_en, !rd_en && !scan_ctrl.check)

endmodule
